@@ rtl/srld_pkg.sv @@
// shared constants and types of the sprite rle decoder
package srld_pkg;

  localparam int unsigned POS_W      = 24;
  localparam int unsigned PIX_POS_W  = 24;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned LIMIT_W    = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 12'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd4096;

  localparam logic [7:0] COUNT_MASK    = 8'h3F;
  localparam logic [7:0] CODE_MASK     = 8'hC0;
  localparam logic [7:0] CODE_ROW_SKIP = 8'h40;
  localparam logic [7:0] CODE_LITERAL  = 8'h00;

  typedef struct packed {
    logic               fmt;
    logic [DIM_W-1:0]   width;
    logic [LIMIT_W-1:0] limit;
  } srld_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } srld_item_t;

  typedef struct packed {
    logic [PIX_POS_W-1:0] position;
    logic [7:0]           index;
    logic [7:0]           alpha;
    logic                 oor;
  } srld_pix_t;

endpackage

@@ rtl/srld_cfg.sv @@
// configuration registers and the registered width times height limit
module srld_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            we_i,
  input  logic [srld_pkg::CFG_IDX_W-1:0]  index_i,
  input  logic [srld_pkg::CFG_DATA_W-1:0] wdata_i,
  output srld_pkg::srld_cfg_t             cfg_o
);
  import srld_pkg::*;

  logic               fmt_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] limit_d;

  assign limit_d = LIMIT_W'(width_q) * LIMIT_W'(height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 1'b0;
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      limit_q  <= LIMIT_RESET;
    end else begin
      // limit is registered from the registered width and height
      limit_q <= limit_d;
      if (we_i) begin
        case (index_i)
          CFG_PIXEL_FORMAT: fmt_q    <= wdata_i[0];
          CFG_IMAGE_WIDTH:  width_q  <= wdata_i[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: height_q <= wdata_i[DIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.fmt   = fmt_q;
  assign cfg_o.width = width_q;
  assign cfg_o.limit = limit_q;

endmodule

@@ rtl/srld_in_reg.sv @@
// input register that holds one stream item until the parser takes it
module srld_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  srld_pkg::srld_item_t item_i,
  output logic                 valid_o,
  output srld_pkg::srld_item_t item_o,
  input  logic                 take_i
);
  import srld_pkg::*;

  logic       valid_q;
  srld_item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  a_hold_until_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && $stable(item_q))
    else $error("held item lost or changed before the parser took it");

endmodule

@@ rtl/srld_parse.sv @@
// stream parser: phase, literal count, held byte and saturating position
module srld_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  srld_pkg::srld_item_t item_i,
  input  srld_pkg::srld_cfg_t  cfg_i,
  output logic                 emit_o,
  output srld_pkg::srld_pix_t  pix_o
);
  import srld_pkg::*;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_CODE = 2'd1;
  localparam logic [1:0] PH_LIT  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  localparam int unsigned AMT_W = 8 + DIM_W;
  localparam int unsigned SUM_W = ((POS_W > AMT_W) ? POS_W : AMT_W) + 1;
  localparam int unsigned CMP_W = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  logic [POS_W-1:0] pos_q, pos_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       lit_q, lit_d;
  logic [7:0]       held_q, held_d;

  logic             do_emit, do_apply;
  logic [7:0]       code, count, idx, alpha, lit_dec;
  logic [AMT_W-1:0] product, amount;
  logic [SUM_W-1:0] sum;

  assign product = AMT_W'(count) * AMT_W'(cfg_i.width);
  assign lit_dec = lit_q - 8'd1;
  assign sum     = SUM_W'(pos_q) + SUM_W'(amount);

  always_comb begin
    do_emit  = 1'b0;
    do_apply = 1'b0;
    code     = CODE_LITERAL;
    count    = '0;
    idx      = '0;
    alpha    = '0;
    phase_d  = phase_q;
    lit_d    = lit_q;
    held_d   = held_q;
    amount   = '0;

    if (!cfg_i.fmt) begin
      if (phase_q == PH_LIT && lit_q != 8'd0) begin
        do_emit = 1'b1;
        idx     = item_i.data;
      end else begin
        do_apply = 1'b1;
        code     = item_i.data & CODE_MASK;
        count    = item_i.data & COUNT_MASK;
      end
    end else begin
      case (phase_q)
        PH_HEAD: begin
          held_d  = item_i.data;
          phase_d = PH_CODE;
        end
        PH_CODE: begin
          do_apply = 1'b1;
          code     = item_i.data;
          count    = held_q;
        end
        PH_LIT: begin
          held_d  = item_i.data;
          phase_d = PH_HIGH;
        end
        default: begin
          // little-endian literal: index is bits 8:1, alpha bits 12:9 times 0x11
          do_emit = 1'b1;
          idx     = {item_i.data[0], held_q[7:1]};
          alpha   = {item_i.data[4:1], item_i.data[4:1]};
        end
      endcase
    end

    if (do_apply) begin
      if (code == CODE_LITERAL) begin
        lit_d   = count;
        phase_d = (count != 8'd0) ? PH_LIT : PH_HEAD;
      end else begin
        amount  = (code == CODE_ROW_SKIP) ? product : AMT_W'(count);
        phase_d = PH_HEAD;
      end
    end

    if (do_emit) begin
      amount  = AMT_W'(1);
      lit_d   = lit_dec;
      phase_d = (lit_dec != 8'd0) ? PH_LIT : PH_HEAD;
    end

    // saturate at the top position
    pos_d = (sum > SUM_W'(POS_MAX)) ? POS_MAX : sum[POS_W-1:0];

    if (item_i.last) begin
      pos_d   = '0;
      phase_d = PH_HEAD;
      lit_d   = '0;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= PH_HEAD;
      lit_q   <= '0;
      held_q  <= '0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      lit_q   <= lit_d;
      held_q  <= held_d;
    end
  end

  assign emit_o         = do_emit;
  assign pix_o.position = PIX_POS_W'(pos_q);
  assign pix_o.index    = idx;
  assign pix_o.alpha    = alpha;
  assign pix_o.oor      = CMP_W'(pos_q) >= CMP_W'(cfg_i.limit);

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last |=> pos_q == '0 && phase_q == PH_HEAD && lit_q == '0)
    else $error("state not cleared after end of image");

  a_byte_fmt_phases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !cfg_i.fmt |=> phase_q != PH_CODE && phase_q != PH_HIGH)
    else $error("8-bit format entered a 16-bit only phase");

  a_pos_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.last |=> pos_q >= $past(pos_q))
    else $error("position moved backward within an image");

endmodule

@@ rtl/srld_out_reg.sv @@
// result register for one pixel write
module srld_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  srld_pkg::srld_pix_t pix_i,
  output logic                free_o,
  output logic                valid_o,
  output srld_pkg::srld_pix_t pix_o,
  input  logic                ready_i
);
  import srld_pkg::*;

  logic      valid_q;
  srld_pix_t pix_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pix_q <= pix_i;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

@@ rtl/sprite_skip_literal_rle_decoder_top.sv @@
// top level of the sprite rle decoder with skip codes
//
// usage: stream bytes enter on the in channel (in_valid_i/in_ready_o, one
// byte and an end-of-image flag per item); pixel writes leave on the out
// channel (out_valid_o/out_ready_i) as position, palette index, alpha and
// an out-of-range flag. header, count and code bytes give no output item.
// configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i):
// index 0 pixel format, 1 image width, 2 image height; write while idle.
// a literal byte passes the input register, then the result register, which
// loads only while free, before its pixel write shows on the out channel.
// throughput: one stream byte per cycle while the result register is free;
// the position update (count times width multiply and saturating add) on
// the parse state is combinational.
// reset: registers go to 8-bit format, 64 by 64, and the parser to the
// start of an image; after an end-of-image byte the parser returns there.
// stall: while out_ready_i is low a waiting result holds, one more byte is
// held in the input register, and then in_ready_o drops.
module sprite_skip_literal_rle_decoder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [srld_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [srld_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       stream_byte_i,
  input  logic                             end_of_image_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [srld_pkg::PIX_POS_W-1:0]   pixel_position_o,
  output logic [7:0]                       color_index_o,
  output logic [7:0]                       alpha_value_o,
  output logic                             out_of_range_o
);
  import srld_pkg::*;

  srld_cfg_t  cfg;
  srld_item_t in_item, held_item;
  srld_pix_t  pix_next, pix_out;
  logic       held_valid, slot_free, fire, emit;

  assign in_item.data = stream_byte_i;
  assign in_item.last = end_of_image_i;

  // an item is parsed only when the result register can take its write
  assign fire = held_valid && slot_free;

  srld_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .index_i (cfg_index_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  srld_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .item_o  (held_item),
    .take_i  (fire)
  );

  srld_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (held_item),
    .cfg_i  (cfg),
    .emit_o (emit),
    .pix_o  (pix_next)
  );

  srld_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && emit),
    .pix_i   (pix_next),
    .free_o  (slot_free),
    .valid_o (out_valid_o),
    .pix_o   (pix_out),
    .ready_i (out_ready_i)
  );

  assign pixel_position_o = pix_out.position;
  assign color_index_o    = pix_out.index;
  assign alpha_value_o    = pix_out.alpha;
  assign out_of_range_o   = pix_out.oor;

endmodule

@@ tb/sprite_skip_literal_rle_decoder_top_tb.sv @@
// testbench of the sprite rle decoder: directed and random streams against a predictor
module sprite_skip_literal_rle_decoder_top_tb;
  import srld_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint unsigned POS_MAX = (64'd1 << POS_W) - 1;

  typedef enum bit [1:0] {
    PH_HEADER  = 2'd0,
    PH_CODE    = 2'd1,
    PH_LITERAL = 2'd2,
    PH_HIGH    = 2'd3
  } parse_phase_e;

  // predicted pixel writes of the decoder, checked in order
  class pixel_scoreboard;
    bit                fmt;
    bit [DIM_W-1:0]    width;
    bit [DIM_W-1:0]    height;
    longint unsigned   pos;
    parse_phase_e      phase;
    bit [7:0]          lits_left;
    bit [7:0]          held;
    srld_pix_t         pixel_q[$];
    int                errors;

    function new();
      fmt    = 1'b0;
      width  = DIM_RESET;
      height = DIM_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      pos       = 0;
      phase     = PH_HEADER;
      lits_left = 8'd0;
      held      = 8'd0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PIXEL_FORMAT: fmt = val[0];
        CFG_IMAGE_WIDTH:  width = val[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height = val[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    // saturating position update
    function void advance(longint unsigned amount);
      longint unsigned room;
      room = POS_MAX - pos;
      pos = (amount >= room) ? POS_MAX : pos + amount;
    endfunction

    function void take_code(bit [7:0] code, bit [7:0] count);
      if (code == CODE_LITERAL) begin
        lits_left = count;
        phase = (count != 0) ? PH_LITERAL : PH_HEADER;
      end else begin
        if (code == CODE_ROW_SKIP) advance(longint'(count) * longint'(width));
        else advance(longint'(count));
        phase = PH_HEADER;
      end
    endfunction

    function void push_pixel(bit [7:0] idx, bit [7:0] alpha);
      srld_pix_t px;
      px.position = pos[PIX_POS_W-1:0];
      px.index    = idx;
      px.alpha    = alpha;
      px.oor      = (pos >= longint'(width) * longint'(height));
      pixel_q.push_back(px);
      advance(1);
      lits_left = lits_left - 8'd1;
      phase = (lits_left != 0) ? PH_LITERAL : PH_HEADER;
    endfunction

    function void note_byte(bit [7:0] b, bit last);
      bit [15:0] raw;
      if (!fmt) begin
        if (phase == PH_LITERAL && lits_left != 0) push_pixel(b, 8'd0);
        else take_code(b & CODE_MASK, b & COUNT_MASK);
      end else begin
        case (phase)
          PH_HEADER: begin
            held  = b;
            phase = PH_CODE;
          end
          PH_CODE: take_code(b, held);
          PH_LITERAL: begin
            held  = b;
            phase = PH_HIGH;
          end
          default: begin
            raw = {b, held};
            push_pixel(raw[8:1], 8'(raw[12:9]) * 8'h11);
          end
        endcase
      end
      if (last) restart();
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(srld_pix_t got);
      srld_pix_t want;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel write, expected none, actual pos 0x%0h idx 0x%0h",
                 $time, got.position, got.index);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        compare_field("pixel_position", want.position, got.position);
        compare_field("color_index", want.index, got.index);
        compare_field("alpha_value", want.alpha, got.alpha);
        compare_field("out_of_range", want.oor, got.oor);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            stream_byte_i = 8'd0;
  logic                  end_of_image_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_POS_W-1:0]  pixel_position_o;
  logic [7:0]            color_index_o;
  logic [7:0]            alpha_value_o;
  logic                  out_of_range_o;

  pixel_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int cycle_count = 0;

  sprite_skip_literal_rle_decoder_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .end_of_image_i   (end_of_image_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .pixel_position_o (pixel_position_o),
    .color_index_o    (color_index_o),
    .alpha_value_o    (alpha_value_o),
    .out_of_range_o   (out_of_range_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    srld_pix_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_byte(stream_byte_i, end_of_image_i);
      if (out_valid_o && out_ready_i) begin
        got.position = pixel_position_o;
        got.index    = color_index_o;
        got.alpha    = alpha_value_o;
        got.oor      = out_of_range_o;
        sb.check_pixel(got);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[sprite_skip_literal_rle_decoder_top] ERROR");
    $finish;
  end

  task automatic send_byte(input bit [7:0] b, input bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    stream_byte_i  <= b;
    end_of_image_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // sender holds off until every predicted pixel write has come out
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // header and skip bytes leave no trace, so give the pipeline time to empty
  task automatic settle();
    wait_results();
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_stream(input bit [7:0] q[$], input bit close);
    foreach (q[i]) begin
      if ($urandom_range(299) == 0) wait_results();
      send_byte(q[i], close && (i == q.size() - 1));
    end
  endtask

  // one image of random runs; now and then plain noise instead
  task automatic send_image();
    bit [7:0] img[$];
    bit [7:0] code;
    int kind;
    int cnt;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 10)) img.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        kind = $urandom_range(9);
        cnt = ($urandom_range(7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
        if (!sb.fmt) begin
          if (kind < 6) begin
            img.push_back(CODE_LITERAL | 8'(cnt));
            repeat (cnt) img.push_back(8'($urandom));
          end else if (kind < 8) begin
            img.push_back(CODE_ROW_SKIP | 8'(cnt % 4));
          end else begin
            img.push_back((8'($urandom_range(2, 3)) << 6) | 8'(cnt));
          end
        end else begin
          if ($urandom_range(39) == 0) cnt = $urandom_range(0, 255);
          if (kind < 6) begin
            img.push_back(8'(cnt));
            img.push_back(CODE_LITERAL);
            repeat (2 * cnt) img.push_back(8'($urandom));
          end else if (kind < 8) begin
            img.push_back(8'(cnt % 4));
            img.push_back(CODE_ROW_SKIP);
          end else begin
            code = 8'($urandom_range(1, 255));
            if (code == CODE_ROW_SKIP) code++;
            img.push_back(8'(cnt));
            img.push_back(code);
          end
        end
      end
    end
    send_stream(img, 1'b1);
  endtask

  task automatic random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) send_image();
    settle();
  endtask

  initial begin
    bit [7:0] q[$];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 8-bit format at reset size: literals, empty run, both skips, out of range
    q = {8'h03, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h45, 8'h82, 8'hC1, 8'h01, 8'hAA,
         8'h7F, 8'h01, 8'h33};
    send_stream(q, 1'b1);
    settle();

    // 16-bit format at the largest size, then saturate the position
    write_reg(CFG_PIXEL_FORMAT, 12'd1);
    write_reg(CFG_IMAGE_WIDTH, 12'd4095);
    write_reg(CFG_IMAGE_HEIGHT, 12'd4095);
    q = {8'h02, CODE_LITERAL, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, CODE_LITERAL};
    send_stream(q, 1'b0);
    repeat (17) begin
      q = {8'hFF, CODE_ROW_SKIP};
      send_stream(q, 1'b0);
    end
    q = {8'h02, CODE_LITERAL, 8'h34, 8'h12, 8'hA5, 8'h5A, 8'h03, 8'h80, 8'h01, 8'h01,
         8'h01, CODE_LITERAL, 8'h00, 8'h01};
    send_stream(q, 1'b1);
    settle();

    // format switched while the parser is in the middle of a run
    q = {8'h03, CODE_LITERAL, 8'h11, 8'h22};
    send_stream(q, 1'b0);
    settle();
    write_reg(CFG_PIXEL_FORMAT, 12'd0);
    q = {8'h77};
    send_stream(q, 1'b0);
    settle();
    write_reg(CFG_PIXEL_FORMAT, 12'd1);
    q = {8'h99};
    send_stream(q, 1'b0);
    settle();
    write_reg(CFG_PIXEL_FORMAT, 12'd0);
    q = {8'h02, 8'h10, 8'h20};
    send_stream(q, 1'b0);
    settle();
    write_reg(CFG_PIXEL_FORMAT, 12'd1);
    q = {8'h05};
    send_stream(q, 1'b0);
    settle();
    write_reg(CFG_PIXEL_FORMAT, 12'd0);
    q = {8'h41};
    send_stream(q, 1'b1);
    settle();

    // zero width: row skips stay put and every write is out of range
    write_reg(CFG_IMAGE_WIDTH, 12'd0);
    q = {8'h45, 8'h01, 8'h10};
    send_stream(q, 1'b1);
    settle();

    write_reg(CFG_IMAGE_WIDTH, 12'd64);
    write_reg(CFG_IMAGE_HEIGHT, 12'd64);
    random_phase(150, 0, 0);

    write_reg(CFG_PIXEL_FORMAT, 12'd1);
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    random_phase(150, 82, 0);

    write_reg(CFG_PIXEL_FORMAT, 12'd0);
    write_reg(CFG_IMAGE_WIDTH, 12'd4095);
    write_reg(CFG_IMAGE_HEIGHT, 12'd1);
    random_phase(150, 0, 82);

    write_reg(CFG_PIXEL_FORMAT, 12'd1);
    write_reg(CFG_IMAGE_WIDTH, 12'($urandom_range(1, 64)));
    write_reg(CFG_IMAGE_HEIGHT, 12'($urandom_range(1, 64)));
    random_phase(150, 37, 37);

    write_reg(CFG_PIXEL_FORMAT, 12'd0);
    write_reg(CFG_IMAGE_WIDTH, 12'd1);
    write_reg(CFG_IMAGE_HEIGHT, 12'd4095);
    random_phase(150, 0, 0);

    repeat (10) @(posedge clk_i);
    if (sb.pixel_q.size() != 0) begin
      $display("%0t: %0d pixel writes expected but never seen", $time, sb.pixel_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[sprite_skip_literal_rle_decoder_top] OK");
    end else begin
      $display("[sprite_skip_literal_rle_decoder_top] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/srld_pkg.sv
rtl/srld_cfg.sv
rtl/srld_in_reg.sv
rtl/srld_parse.sv
rtl/srld_out_reg.sv
rtl/sprite_skip_literal_rle_decoder_top.sv
tb/sprite_skip_literal_rle_decoder_top_tb.sv
